/* design/apu_pkg.sv */
// ----------------------------------------------------------------------------
// apu_pkg
// Shared types and constants of the adagrad parameter update engine: word
// formats, command codes, table row layout and controller interface.
// ----------------------------------------------------------------------------
package apu_pkg;

   localparam int unsigned NUM_FEATURES_DEFAULT = 1024;
   localparam int unsigned FRAC_BITS = 16;

   localparam int unsigned IDX_W = 10;
   localparam int unsigned GRAD_W = 32;
   localparam int unsigned STEP_W = 24;
   localparam int unsigned PARAM_W = 32;
   localparam int unsigned ACC_W = 48;

   localparam int unsigned RAD_W = 80;
   localparam int unsigned ROOT_W = 41;
   localparam int unsigned PROD_W = 64;
   localparam int unsigned DVD_W = 56;
   localparam int unsigned ROOT_STEPS = 40;
   localparam int unsigned DIV_STEPS = 56;
   localparam int unsigned ITER_W = 6;

   localparam logic [STEP_W-1:0] DEFAULT_STEP_RESET = 24'd65536;

   localparam logic [1:0] CMD_UPDATE = 2'd0;
   localparam logic [1:0] CMD_SET_STEP = 2'd1;
   localparam logic [1:0] CMD_READ = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]               command;
      logic [IDX_W-1:0]         feature_index;
      logic signed [GRAD_W-1:0] gradient;
      logic [STEP_W-1:0]        step_size;
   } req_type;

   typedef struct packed {
      logic signed [PARAM_W-1:0] param_value;
      logic [ACC_W-1:0]          sq_grad_sum;
      logic                      saturated;
   } rsp_type;

   typedef struct packed {
      logic [ACC_W-1:0]   sq;
      logic [PARAM_W-1:0] param;
      logic [STEP_W-1:0]  step;
      logic               step_valid;
   } row_type;

   localparam int unsigned ROW_W = $bits(row_type);

   typedef struct packed {
      logic clear;
      logic accept;
      logic read;
      logic square;
      logic accum;
      logic root_init;
      logic root_step;
      logic div_init;
      logic div_step;
      logic finish_upd;
      logic finish_other;
   } ctl_type;

   typedef struct packed {
      logic clear_last;
      logic update;
      logic root_last;
      logic div_last;
   } sts_type;

endpackage

/* design/adagrad_parameter_update.sv */
// ----------------------------------------------------------------------------
// adagrad_parameter_update
// Per-feature adagrad engine: accumulates squared gradients and updates
// each feature's parameter by step * g / sqrt(1 + accumulator).
//
// req_word is taken at a clock edge with start high and busy low; commands
// are update, set step override and read. One rsp_word per request, shown
// for one cycle with rsp_valid; the receiver cannot stall, so it must take
// every result in that cycle. csr_data writes the default step whenever
// csr_valid is high (csr_ready is always high); write it only while idle.
// An accept is followed by the READ and EXEC states; read, set step and an
// index beyond the table finish there, while an update goes on through the
// accumulate step, the 40-step square root and the 56-step divider, one bit
// per cycle each. busy drops in the cycle rsp_valid shows, so a new request
// may follow at once. After reset the feature table is cleared, one entry a
// cycle, with busy high until the last entry is cleared; no request is taken before.
// ----------------------------------------------------------------------------
module adagrad_parameter_update #(
   parameter int unsigned NUM_FEATURES = apu_pkg::NUM_FEATURES_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  apu_pkg::req_type           req_word,
   output logic                       rsp_valid,
   output apu_pkg::rsp_type           rsp_word,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [apu_pkg::STEP_W-1:0] csr_data
);

   apu_pkg::ctl_type ctl;
   apu_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   apu_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .ctl   (ctl),
      .busy  (busy)
   );

   apu_datapath #(
      .NUM_FEATURES (NUM_FEATURES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .sts       (sts),
      .req_word  (req_word),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

`ifndef SYNTH
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a request in flight");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but engine not busy");

   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two results in consecutive cycles");
`endif

endmodule

/* design/apu_ram.sv */
// ----------------------------------------------------------------------------
// apu_ram
// Generic single-clock RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module apu_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/apu_ctrl.sv */
// ----------------------------------------------------------------------------
// apu_ctrl
// Controller state machine: table clearing, command sequencing and the
// square root and division iterations of an update.
// ----------------------------------------------------------------------------
module apu_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  apu_pkg::sts_type sts,
   output apu_pkg::ctl_type ctl,
   output logic             busy
);

   typedef enum logic [8:0] {
      ST_CLEAR = 9'b000000001,
      ST_IDLE  = 9'b000000010,
      ST_READ  = 9'b000000100,
      ST_EXEC  = 9'b000001000,
      ST_ACC   = 9'b000010000,
      ST_RINIT = 9'b000100000,
      ST_ROOT  = 9'b001000000,
      ST_DINIT = 9'b010000000,
      ST_DIV   = 9'b100000000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      fin_ff;
   logic      fin_in;

   always_comb begin
      state_in = state_ff;
      fin_in   = 1'b0;
      ctl      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            ctl.clear = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               ctl.accept = 1'b1;
               state_in   = ST_READ;
            end
         end
         ST_READ: begin
            ctl.read = 1'b1;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (sts.update) begin
               ctl.square = 1'b1;
               state_in   = ST_ACC;
            end else begin
               ctl.finish_other = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         ST_ACC: begin
            ctl.accum = 1'b1;
            state_in  = ST_RINIT;
         end
         ST_RINIT: begin
            ctl.root_init = 1'b1;
            state_in      = ST_ROOT;
         end
         ST_ROOT: begin
            ctl.root_step = 1'b1;
            if (sts.root_last) begin
               state_in = ST_DINIT;
            end
         end
         ST_DINIT: begin
            ctl.div_init = 1'b1;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            if (fin_ff) begin
               ctl.finish_upd = 1'b1;
               state_in       = ST_IDLE;
            end else begin
               ctl.div_step = 1'b1;
               fin_in       = sts.div_last;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         fin_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         fin_ff   <= fin_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

/* design/apu_datapath.sv */
// ----------------------------------------------------------------------------
// apu_datapath
// Datapath: feature table, shared multiplier, accumulator add, bit-serial
// square root and divider, parameter update and result register.
// ----------------------------------------------------------------------------
module apu_datapath #(
   parameter int unsigned NUM_FEATURES = apu_pkg::NUM_FEATURES_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  apu_pkg::ctl_type                 ctl,
   output apu_pkg::sts_type                 sts,
   input  apu_pkg::req_type                 req_word,
   input  logic                             csr_valid,
   input  logic [apu_pkg::STEP_W-1:0]       csr_data,
   output logic                             rsp_valid,
   output apu_pkg::rsp_type                 rsp_word
);

   localparam int unsigned ADDR_W = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
   localparam int unsigned ROOT_LAST = apu_pkg::ROOT_STEPS - 1;
   localparam int unsigned DIV_LAST = apu_pkg::DIV_STEPS - 1;
   localparam int unsigned PS_W = apu_pkg::DVD_W + 2;

   // latched request word
   apu_pkg::req_type                 req_ff;
   logic                             in_range_ff;
   logic [apu_pkg::STEP_W-1:0]       dstep_ff;

   apu_pkg::row_type                 row_ff;
   apu_pkg::row_type                 rd_row;
   apu_pkg::row_type                 wr_row;
   logic [apu_pkg::ROW_W-1:0]        rd_data;
   logic                             wr_en;
   logic [ADDR_W-1:0]                wr_addr;
   logic [ADDR_W-1:0]                idx_addr;
   logic [ADDR_W-1:0]                clear_addr_ff;

   logic [apu_pkg::PROD_W-1:0]       prod_ff;
   logic [apu_pkg::ACC_W-1:0]        acc_ff;
   logic [apu_pkg::ACC_W-1:0]        acc_in;
   logic                             sat_ff;
   logic                             sat_in;
   logic [apu_pkg::ITER_W-1:0]       iter_ff;

   logic [apu_pkg::RAD_W-1:0]        rad_ff;
   logic [apu_pkg::ROOT_W:0]         rem_ff;
   logic [apu_pkg::ROOT_W-1:0]       root_ff;
   logic [apu_pkg::ROOT_W+2:0]       rem_sh;
   logic [apu_pkg::ROOT_W+2:0]       trial;

   logic [apu_pkg::DVD_W-1:0]        dvd_ff;
   logic [apu_pkg::DVD_W-1:0]        quo_ff;
   logic [apu_pkg::ROOT_W-1:0]       drem_ff;
   logic [apu_pkg::ROOT_W:0]         dsh;

   logic                             neg;
   logic [apu_pkg::GRAD_W-1:0]       mag;
   logic [apu_pkg::GRAD_W-1:0]       mult_b;
   logic [apu_pkg::STEP_W-1:0]       step_sel;
   logic [apu_pkg::ACC_W:0]          acc_sum;
   logic [apu_pkg::ACC_W:0]          r_val;
   logic signed [PS_W-1:0]           psum;
   logic                             psat;
   logic [apu_pkg::PARAM_W-1:0]      p_new;

   logic                             rsp_valid_ff;
   apu_pkg::rsp_type                 rsp_ff;

   assign idx_addr = ADDR_W'(req_ff.feature_index);
   assign rd_row   = apu_pkg::row_type'(rd_data);

   // status
   assign sts.clear_last = (clear_addr_ff == ADDR_W'(NUM_FEATURES - 1));
   assign sts.update     = in_range_ff && (req_ff.command == apu_pkg::CMD_UPDATE);
   assign sts.root_last  = (iter_ff == apu_pkg::ITER_W'(ROOT_LAST));
   assign sts.div_last   = (iter_ff == apu_pkg::ITER_W'(DIV_LAST));

   // gradient magnitude and shared multiplier operand
   assign neg      = req_ff.gradient[apu_pkg::GRAD_W-1];
   assign mag      = neg ? (~req_ff.gradient + 1'b1) : req_ff.gradient;
   assign step_sel = row_ff.step_valid ? row_ff.step : dstep_ff;
   assign mult_b   = ctl.square ? mag : apu_pkg::GRAD_W'(step_sel);

   // saturating accumulator add
   always_comb begin
      acc_sum = {1'b0, row_ff.sq}
              + {1'b0, apu_pkg::ACC_W'(prod_ff >> apu_pkg::FRAC_BITS)};
      if (acc_sum[apu_pkg::ACC_W]) begin
         acc_in = '1;
         sat_in = 1'b1;
      end else begin
         acc_in = acc_sum[apu_pkg::ACC_W-1:0];
         sat_in = 1'b0;
      end
   end

   assign r_val = {1'b0, acc_ff} + ((apu_pkg::ACC_W+1)'(1) << apu_pkg::FRAC_BITS);

   // square root step
   assign rem_sh = {rem_ff, rad_ff[apu_pkg::RAD_W-1 -: 2]};
   assign trial  = {1'b0, root_ff, 2'b01};

   // division step
   assign dsh = {drem_ff, dvd_ff[apu_pkg::DVD_W-1]};

   // parameter update with saturation
   always_comb begin
      psum = PS_W'(signed'(row_ff.param))
           + (neg ? -signed'({2'b00, quo_ff}) : signed'({2'b00, quo_ff}));
      psat = (psum[PS_W-1:apu_pkg::PARAM_W-1] != '0)
          && (psum[PS_W-1:apu_pkg::PARAM_W-1] != '1);
      if (psat) begin
         p_new = psum[PS_W-1] ? {1'b1, {(apu_pkg::PARAM_W-1){1'b0}}}
                              : {1'b0, {(apu_pkg::PARAM_W-1){1'b1}}};
      end else begin
         p_new = psum[apu_pkg::PARAM_W-1:0];
      end
   end

   // table write port
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_addr;
      wr_row  = row_ff;
      if (ctl.clear) begin
         wr_en   = 1'b1;
         wr_addr = clear_addr_ff;
         wr_row  = '0;
      end else if (ctl.finish_upd) begin
         wr_en        = 1'b1;
         wr_row.sq    = acc_ff;
         wr_row.param = p_new;
      end else if (ctl.finish_other && in_range_ff
                   && (req_ff.command == apu_pkg::CMD_SET_STEP)) begin
         wr_en             = 1'b1;
         wr_row            = rd_row;
         wr_row.step       = req_ff.step_size;
         wr_row.step_valid = 1'b1;
      end
   end

   apu_ram #(
      .WIDTH (apu_pkg::ROW_W),
      .DEPTH (NUM_FEATURES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_row),
      .rd_en   (ctl.read),
      .rd_addr (idx_addr),
      .rd_data (rd_data)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_addr_ff <= '0;
         dstep_ff      <= apu_pkg::DEFAULT_STEP_RESET;
         rsp_valid_ff  <= 1'b0;
         iter_ff       <= '0;
      end else begin
         if (ctl.clear) begin
            clear_addr_ff <= clear_addr_ff + 1'b1;
         end
         if (csr_valid) begin
            dstep_ff <= csr_data;
         end
         rsp_valid_ff <= ctl.finish_upd || ctl.finish_other;
         if (ctl.root_init || ctl.div_init) begin
            iter_ff <= '0;
         end else if (ctl.root_step || ctl.div_step) begin
            iter_ff <= iter_ff + 1'b1;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         req_ff      <= req_word;
         in_range_ff <= (32'(req_word.feature_index) < NUM_FEATURES);
      end
      if (ctl.square) begin
         row_ff <= rd_row;
      end
      if (ctl.square || ctl.accum) begin
         prod_ff <= apu_pkg::PROD_W'(mag) * apu_pkg::PROD_W'(mult_b);
      end
      if (ctl.accum) begin
         acc_ff <= acc_in;
         sat_ff <= sat_in;
      end
      if (ctl.root_init) begin
         rad_ff  <= apu_pkg::RAD_W'(r_val) << apu_pkg::FRAC_BITS;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (ctl.root_step) begin
         rad_ff <= rad_ff << 2;
         if (rem_sh >= trial) begin
            rem_ff  <= (apu_pkg::ROOT_W+1)'(rem_sh - trial);
            root_ff <= {root_ff[apu_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_sh[apu_pkg::ROOT_W:0];
            root_ff <= {root_ff[apu_pkg::ROOT_W-2:0], 1'b0};
         end
      end
      if (ctl.div_init) begin
         dvd_ff  <= prod_ff[apu_pkg::DVD_W-1:0];
         quo_ff  <= '0;
         drem_ff <= '0;
      end else if (ctl.div_step) begin
         dvd_ff <= dvd_ff << 1;
         if (dsh >= {1'b0, root_ff}) begin
            drem_ff <= apu_pkg::ROOT_W'(dsh - {1'b0, root_ff});
            quo_ff  <= {quo_ff[apu_pkg::DVD_W-2:0], 1'b1};
         end else begin
            drem_ff <= dsh[apu_pkg::ROOT_W-1:0];
            quo_ff  <= {quo_ff[apu_pkg::DVD_W-2:0], 1'b0};
         end
      end
      if (ctl.finish_upd) begin
         rsp_ff.param_value <= p_new;
         rsp_ff.sq_grad_sum <= acc_ff;
         rsp_ff.saturated   <= sat_ff || psat;
      end else if (ctl.finish_other) begin
         if (in_range_ff) begin
            rsp_ff.param_value <= rd_row.param;
            rsp_ff.sq_grad_sum <= rd_row.sq;
         end else begin
            rsp_ff.param_value <= '0;
            rsp_ff.sq_grad_sum <= '0;
         end
         rsp_ff.saturated <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule
